// File: src/owtr_pkg.sv
package owtr_pkg;

	// Register map, index of each 32-bit word
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_PRE_RESET   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_RESET_LOW   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RECOVER     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SLOT        = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_DLY  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CONV_WAIT   = 3'd5;

	// Timing registers seen by the sequencer
	typedef struct packed {
		logic [15:0] pre_reset_ticks;
		logic [15:0] reset_low_ticks;
		logic [15:0] reset_recover_ticks;
		logic [15:0] slot_ticks;
		logic [15:0] sample_delay_ticks;
		logic [15:0] conversion_wait_ticks;
	} owtr_cfg_t;

	// Per-tick result of the sequencer
	typedef struct packed {
		logic               pull;
		logic               busy;
		logic               valid;
		logic signed [15:0] raw;
	} owtr_res_t;

	// Hundredths of a degree: trunc((25*raw+2)/4), clamped to -5500..12500
	function automatic logic signed [14:0] centi_of(input logic signed [15:0] raw);
		logic signed [21:0] r;
		logic signed [21:0] p;
		logic signed [21:0] q;
		r = 22'(raw);
		p = (r <<< 4) + (r <<< 3) + r + 22'sd2;
		// round toward zero for negative values
		q = p[21] ? ((p + 22'sd3) >>> 2) : (p >>> 2);
		if (q < -22'sd5500) begin
			q = -22'sd5500;
		end else if (q > 22'sd12500) begin
			q = 22'sd12500;
		end
		return q[14:0];
	endfunction

endpackage

// File: src/owtr_seq.sv
module owtr_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic                 start_req,
	input  logic                 line_in,
	input  owtr_pkg::owtr_cfg_t  cfg,
	output owtr_pkg::owtr_res_t  res
);

	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_PRE    = 4'd1;
	localparam logic [3:0] PH_RLOW   = 4'd2;
	localparam logic [3:0] PH_RREC   = 4'd3;
	localparam logic [3:0] PH_WRITE  = 4'd4;
	localparam logic [3:0] PH_CWAIT  = 4'd5;
	localparam logic [3:0] PH_RDLOW  = 4'd6;
	localparam logic [3:0] PH_RDDLY  = 4'd7;
	localparam logic [3:0] PH_RDREST = 4'd8;
	localparam logic [3:0] PH_DONE   = 4'd9;

	localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
	localparam logic [7:0] CMD_CONVERT   = 8'h44;
	localparam logic [7:0] CMD_READ_PAD  = 8'hBE;

	// Command byte for each write step
	function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd1:    b = CMD_CONVERT;
			2'd3:    b = CMD_READ_PAD;
			default: b = CMD_SKIP_ROM;
		endcase
		return b;
	endfunction

	logic [3:0]  phase_q, ph_n;
	logic [15:0] tick_q, tc_n;
	logic [2:0]  step_q, st_n;
	logic [2:0]  bit_q, bi_n;
	logic [7:0]  shift_q, sb_n;
	logic [7:0]  low_q, lb_n;
	logic [15:0] last_q, lr_n;
	logic [16:0] tc_inc;
	logic [15:0] phase_len;
	logic        do_settle;
	logic        pull, busy, valid;

	// Length of the current phase; a zero length ends it after one tick
	always_comb begin
		unique case (phase_q)
			PH_PRE:    phase_len = cfg.pre_reset_ticks;
			PH_RLOW:   phase_len = cfg.reset_low_ticks;
			PH_RREC:   phase_len = cfg.reset_recover_ticks;
			PH_WRITE:  phase_len = cfg.slot_ticks;
			PH_CWAIT:  phase_len = cfg.conversion_wait_ticks;
			PH_RDDLY:  phase_len = cfg.sample_delay_ticks;
			PH_RDREST: phase_len = cfg.slot_ticks;
			default:   phase_len = 16'd1;
		endcase
	end

	// Next state for one tick
	always_comb begin
		ph_n = phase_q;
		tc_n = tick_q;
		st_n = step_q;
		bi_n = bit_q;
		sb_n = shift_q;
		lb_n = low_q;
		lr_n = last_q;
		pull = 1'b0;
		busy = 1'b0;
		valid = 1'b0;
		do_settle = 1'b0;
		tc_inc = {1'b0, tick_q} + 17'd1;

		if (phase_q == PH_IDLE || phase_q == PH_DONE) begin
			valid = (phase_q == PH_DONE);
			ph_n = PH_IDLE;
			if (start_req) begin
				ph_n = PH_PRE;
				tc_n = '0;
				st_n = '0;
				bi_n = '0;
				do_settle = 1'b1;
			end
		end else begin
			busy = 1'b1;
			if (phase_q == PH_RLOW || phase_q == PH_RDLOW) begin
				pull = 1'b1;
			end else if (phase_q == PH_WRITE) begin
				pull = (tick_q == '0) || !shift_q[0];
			end
			// sample the line on the first tick after the sample delay of a read slot
			if (phase_q == PH_RDREST && tick_q == '0) begin
				sb_n = {line_in, shift_q[7:1]};
			end
			tc_n = tc_inc[15:0];
			if (tc_inc >= {1'b0, phase_len}) begin
				tc_n = '0;
				do_settle = 1'b1;
				unique case (phase_q)
					PH_PRE:   ph_n = PH_RLOW;
					PH_RLOW:  ph_n = PH_RREC;
					PH_RREC: begin
						sb_n = cmd_byte(step_q[1:0]);
						bi_n = '0;
						ph_n = PH_WRITE;
					end
					PH_WRITE: begin
						sb_n = {1'b0, shift_q[7:1]};
						if (bit_q != 3'd7) begin
							bi_n = bit_q + 3'd1;
						end else begin
							bi_n = '0;
							st_n = step_q + 3'd1;
							if (st_n == 3'd2) begin
								ph_n = PH_CWAIT;
							end else if (st_n[2]) begin
								sb_n = '0;
								ph_n = PH_RDLOW;
							end else begin
								sb_n = cmd_byte(st_n[1:0]);
							end
						end
					end
					PH_CWAIT: ph_n = PH_PRE;
					PH_RDLOW: ph_n = PH_RDDLY;
					PH_RDDLY: ph_n = PH_RDREST;
					PH_RDREST: begin
						if (bit_q != 3'd7) begin
							bi_n = bit_q + 3'd1;
							ph_n = PH_RDLOW;
						end else if (step_q == 3'd4) begin
							// low byte in, go for the high byte
							lb_n = sb_n;
							st_n = 3'd5;
							sb_n = '0;
							bi_n = '0;
							ph_n = PH_RDLOW;
						end else begin
							lr_n = {sb_n, low_q};
							bi_n = '0;
							ph_n = PH_DONE;
						end
					end
					default:  ph_n = PH_IDLE;
				endcase
			end
		end

		// Skip the pre-reset, recovery, sample-delay and conversion-wait phases when their length is zero
		if (do_settle) begin
			if (ph_n == PH_CWAIT && cfg.conversion_wait_ticks == '0) begin
				ph_n = PH_PRE;
			end
			if (ph_n == PH_PRE && cfg.pre_reset_ticks == '0) begin
				ph_n = PH_RLOW;
			end
			if (ph_n == PH_RREC && cfg.reset_recover_ticks == '0) begin
				sb_n = cmd_byte(st_n[1:0]);
				bi_n = '0;
				ph_n = PH_WRITE;
			end
			if (ph_n == PH_RDDLY && cfg.sample_delay_ticks == '0) begin
				ph_n = PH_RDREST;
			end
		end
	end

	// Advance once per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			step_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			low_q   <= '0;
			last_q  <= '0;
		end else if (step_en) begin
			phase_q <= ph_n;
			tick_q  <= tc_n;
			step_q  <= st_n;
			bit_q   <= bi_n;
			shift_q <= sb_n;
			low_q   <= lb_n;
			last_q  <= lr_n;
		end
	end

	assign res.pull  = pull;
	assign res.busy  = busy;
	assign res.valid = valid;
	assign res.raw   = lr_n;

endmodule

// File: src/one_wire_temperature_reader.sv
// Single-wire temperature reader. Each input item is one bus tick: it carries
// start_req and the sampled line level, and yields exactly one result item
// with the pull-low drive for that tick, busy, a one-tick reading_valid, and
// the latest raw reading with its value in hundredths of a degree. One item
// is taken per clock; the sequencer's next state for a tick is formed
// combinationally and each result is held in an output register, so input is
// stalled only while that register is full and the output side stalls.
// Each result shows the cycle after its item is taken. Timing of reset pulses
// and bit slots comes from the six APB registers, which should be written only while idle.
module one_wire_temperature_reader (
	input  logic               clk,
	input  logic               arst_n,
	// input items
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               start_req,
	input  logic               line_in,
	// result items
	output logic               out_valid,
	input  logic               out_stall,
	output logic               line_pull_low,
	output logic               busy_res,
	output logic               reading_valid,
	output logic signed [15:0] raw_reading,
	output logic signed [14:0] temperature_centi,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	owtr_pkg::owtr_cfg_t cfg_q;
	owtr_pkg::owtr_res_t res;
	logic [owtr_pkg::REG_IDX_W-1:0] reg_idx;
	logic cfg_wr;
	logic in_acc;
	logic out_valid_q;
	logic pull_q, busy_q, rvalid_q;
	logic signed [15:0] raw_q;
	logic signed [14:0] centi_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Write timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pre_reset_ticks       <= 16'd4;
			cfg_q.reset_low_ticks       <= 16'd100;
			cfg_q.reset_recover_ticks   <= 16'd40;
			cfg_q.slot_ticks            <= 16'd10;
			cfg_q.sample_delay_ticks    <= 16'd0;
			cfg_q.conversion_wait_ticks <= 16'd0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				owtr_pkg::REG_PRE_RESET:  cfg_q.pre_reset_ticks       <= pwdata[15:0];
				owtr_pkg::REG_RESET_LOW:  cfg_q.reset_low_ticks       <= pwdata[15:0];
				owtr_pkg::REG_RECOVER:    cfg_q.reset_recover_ticks   <= pwdata[15:0];
				owtr_pkg::REG_SLOT:       cfg_q.slot_ticks            <= pwdata[15:0];
				owtr_pkg::REG_SAMPLE_DLY: cfg_q.sample_delay_ticks    <= pwdata[15:0];
				owtr_pkg::REG_CONV_WAIT:  cfg_q.conversion_wait_ticks <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back timing registers
	always_comb begin
		unique case (reg_idx)
			owtr_pkg::REG_PRE_RESET:  prdata = {16'd0, cfg_q.pre_reset_ticks};
			owtr_pkg::REG_RESET_LOW:  prdata = {16'd0, cfg_q.reset_low_ticks};
			owtr_pkg::REG_RECOVER:    prdata = {16'd0, cfg_q.reset_recover_ticks};
			owtr_pkg::REG_SLOT:       prdata = {16'd0, cfg_q.slot_ticks};
			owtr_pkg::REG_SAMPLE_DLY: prdata = {16'd0, cfg_q.sample_delay_ticks};
			owtr_pkg::REG_CONV_WAIT:  prdata = {16'd0, cfg_q.conversion_wait_ticks};
			default:                  prdata = '0;
		endcase
	end

	// Take an item unless a held result is stalled
	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	owtr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (in_acc),
		.start_req (start_req),
		.line_in   (line_in),
		.cfg       (cfg_q),
		.res       (res)
	);

	// Output valid: set on accept, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the result of each accepted item
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pull_q   <= res.pull;
			busy_q   <= res.busy;
			rvalid_q <= res.valid;
			raw_q    <= res.raw;
			centi_q  <= owtr_pkg::centi_of(res.raw);
		end
	end

	assign out_valid         = out_valid_q;
	assign line_pull_low     = pull_q;
	assign busy_res          = busy_q;
	assign reading_valid     = rvalid_q;
	assign raw_reading       = raw_q;
	assign temperature_centi = centi_q;

endmodule

// File: src/owtr_checker.sv
module owtr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               line_pull_low,
	input logic               busy_res,
	input logic               reading_valid,
	input logic signed [15:0] raw_reading,
	input logic signed [14:0] temperature_centi
);

	// Hold a stalled result item
	property p_stall_hold;
		@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(raw_reading)
			&& $stable(temperature_centi) && $stable(line_pull_low)
			&& $stable(busy_res) && $stable(reading_valid);
	endproperty
	a_stall_hold: assert property (p_stall_hold) else $error("stalled item changed");

	// Input stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// The line is pulled only during a sequence
	a_pull_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_pull_low |-> busy_res)
		else $error("line pulled while idle");

	// A completed reading is reported on a tick that is not busy
	a_valid_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reading_valid |-> !busy_res)
		else $error("reading reported while busy");

endmodule

bind one_wire_temperature_reader owtr_checker u_owtr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_stall          (in_stall),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.line_pull_low     (line_pull_low),
	.busy_res          (busy_res),
	.reading_valid     (reading_valid),
	.raw_reading       (raw_reading),
	.temperature_centi (temperature_centi)
);
